### hdl/fdf_pkg.sv
package fdf_pkg;

  // Register map: register n sits at byte address 4*n.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_FREEFALL_LEVEL    = 3'd0;
  localparam logic [2:0] REG_IMPACT_LEVEL      = 3'd1;
  localparam logic [2:0] REG_STILL_ACCEL_LEVEL = 3'd2;
  localparam logic [2:0] REG_STILL_GYRO_LEVEL  = 3'd3;
  localparam logic [2:0] REG_TILT_LEVEL        = 3'd4;
  localparam logic [2:0] REG_FREEFALL_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_STILL_TIMEOUT     = 3'd6;
  localparam logic [2:0] REG_CONFIRM_HOLD      = 3'd7;

  localparam logic [15:0] RST_FREEFALL_LEVEL    = 16'd500;
  localparam logic [15:0] RST_IMPACT_LEVEL      = 16'd2500;
  localparam logic [15:0] RST_STILL_ACCEL_LEVEL = 16'd1200;
  localparam logic [15:0] RST_STILL_GYRO_LEVEL  = 16'd300;
  localparam logic [15:0] RST_TILT_LEVEL        = 16'd6000;
  localparam logic [31:0] RST_FREEFALL_TIMEOUT  = 32'd5000;
  localparam logic [31:0] RST_STILL_TIMEOUT     = 32'd10000;
  localparam logic [31:0] RST_CONFIRM_HOLD      = 32'd30000;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [6:0] CONF_NORMAL    = 7'd0;
  localparam logic [6:0] CONF_FREEFALL  = 7'd30;
  localparam logic [6:0] CONF_IMPACT    = 7'd60;
  localparam logic [6:0] CONF_STATIC    = 7'd80;
  localparam logic [6:0] CONF_CONFIRMED = 7'd90;

  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  typedef enum logic [2:0] {
    PH_NORMAL    = 3'd0,
    PH_FREEFALL  = 3'd1,
    PH_IMPACT    = 3'd2,
    PH_STATIC    = 3'd3,
    PH_CONFIRMED = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] freefall_level;
    logic [15:0] impact_level;
    logic [15:0] still_accel_level;
    logic [15:0] still_gyro_level;
    logic [15:0] tilt_level;
    logic [31:0] freefall_timeout_ms;
    logic [31:0] still_timeout_ms;
    logic [31:0] confirm_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        now_ms;
    logic [15:0]        accel_magnitude;
    logic [15:0]        gyro_magnitude;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic [31:0]        entry_time;
    logic [15:0]        peak_accel;
    logic signed [15:0] start_pitch;
    logic signed [15:0] start_roll;
  } fsm_t;

  typedef struct packed {
    logic [2:0]  fall_state;
    logic        fall_confirmed;
    logic        alert_pulse;
    logic [6:0]  confidence_pct;
    logic [15:0] peak_impact;
    logic [1:0]  fall_direction;
    logic [31:0] state_entry_ms;
  } res_t;

endpackage

### hdl/fdf_step.sv
module fdf_step
  import fdf_pkg::*;
(
  input  cfg_t  cfg,
  input  fsm_t  cur,
  input  item_t item,
  output fsm_t  nxt,
  output res_t  res
);

  logic [31:0]        elapsed;
  logic signed [16:0] d_pitch;
  logic signed [16:0] d_roll;
  logic [16:0]        abs_dp;
  logic [16:0]        abs_dr;
  logic [16:0]        abs_p;
  logic [16:0]        abs_r;
  logic signed [16:0] p_ext;
  logic signed [16:0] r_ext;
  logic               tilt_hit;
  logic               still;

  always_comb begin
    elapsed  = item.now_ms - cur.entry_time;
    p_ext    = {item.pitch_angle[15], item.pitch_angle};
    r_ext    = {item.roll_angle[15], item.roll_angle};
    d_pitch  = p_ext - {cur.start_pitch[15], cur.start_pitch};
    d_roll   = r_ext - {cur.start_roll[15], cur.start_roll};
    abs_dp   = d_pitch[16] ? 17'(-d_pitch) : 17'(d_pitch);
    abs_dr   = d_roll[16] ? 17'(-d_roll) : 17'(d_roll);
    abs_p    = p_ext[16] ? 17'(-p_ext) : 17'(p_ext);
    abs_r    = r_ext[16] ? 17'(-r_ext) : 17'(r_ext);
    tilt_hit = (abs_dp > {1'b0, cfg.tilt_level}) || (abs_dr > {1'b0, cfg.tilt_level});
    still    = (item.accel_magnitude < cfg.still_accel_level) &&
               (item.gyro_magnitude < cfg.still_gyro_level);
  end

  // Next state: at most one transition for each item.
  always_comb begin
    nxt = cur;
    if (item.req_type == REQ_CLEAR) begin
      nxt.phase      = PH_NORMAL;
      nxt.peak_accel = '0;
    end else begin
      case (cur.phase)
        PH_FREEFALL: begin
          if (item.accel_magnitude > cur.peak_accel) begin
            nxt.peak_accel = item.accel_magnitude;
          end
          if (item.accel_magnitude > cfg.impact_level) begin
            nxt.phase      = PH_IMPACT;
            nxt.entry_time = item.now_ms;
          end else if (elapsed > cfg.freefall_timeout_ms) begin
            nxt.phase = PH_NORMAL;
          end
        end
        PH_IMPACT: begin
          if (still) begin
            nxt.phase      = PH_STATIC;
            nxt.entry_time = item.now_ms;
          end
        end
        PH_STATIC: begin
          if (tilt_hit) begin
            nxt.phase      = PH_CONFIRMED;
            nxt.entry_time = item.now_ms;
          end else if (elapsed > cfg.still_timeout_ms) begin
            nxt.phase      = PH_NORMAL;
            nxt.peak_accel = '0;
          end
        end
        PH_CONFIRMED: begin
          if (elapsed > cfg.confirm_hold_ms) begin
            nxt.phase      = PH_NORMAL;
            nxt.peak_accel = '0;
          end
        end
        default: begin
          nxt.phase = PH_NORMAL;
          if (item.accel_magnitude < cfg.freefall_level) begin
            nxt.phase       = PH_FREEFALL;
            nxt.entry_time  = item.now_ms;
            nxt.start_pitch = item.pitch_angle;
            nxt.start_roll  = item.roll_angle;
          end
        end
      endcase
    end
  end

  // Most result fields come from the state after the update.
  always_comb begin
    res.fall_state     = nxt.phase;
    res.fall_confirmed = (nxt.phase == PH_CONFIRMED);
    res.alert_pulse    = (nxt.phase == PH_CONFIRMED) && (cur.phase != PH_CONFIRMED);
    res.peak_impact    = nxt.peak_accel;
    res.state_entry_ms = nxt.entry_time;
    case (nxt.phase)
      PH_FREEFALL:  res.confidence_pct = CONF_FREEFALL;
      PH_IMPACT:    res.confidence_pct = CONF_IMPACT;
      PH_STATIC:    res.confidence_pct = CONF_STATIC;
      PH_CONFIRMED: res.confidence_pct = CONF_CONFIRMED;
      default:      res.confidence_pct = CONF_NORMAL;
    endcase
    if (abs_p > abs_r) begin
      res.fall_direction = (p_ext > 17'sd0) ? DIR_FORWARD : DIR_BACKWARD;
    end else begin
      res.fall_direction = (r_ext > 17'sd0) ? DIR_LEFT : DIR_RIGHT;
    end
  end

endmodule

### hdl/fall_detect_fsm.sv
// Pipeline: an accepted item is held in the input register and moves on into the result
// register, with one stage of compare-and-update logic between them; a result that is not
// taken holds the next item back in the input register.
// Throughput: one item per cycle while results are taken.
// Reset (rst, synchronous, active high) empties both stages, returns the detector to the
// normal state with zeroed time, peak and start angles, and loads the register defaults.
module fall_detect_fsm
  import fdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [31:0]         now_ms,
  input  logic [15:0]         accel_magnitude,
  input  logic [15:0]         gyro_magnitude,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  roll_angle,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          fall_state,
  output logic                fall_confirmed,
  output logic                alert_pulse,
  output logic [6:0]          confidence_pct,
  output logic [15:0]         peak_impact,
  output logic [1:0]          fall_direction,
  output logic [31:0]         state_entry_ms
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid;
  fsm_t  fsm;
  fsm_t  fsm_next;
  res_t  res_next;
  res_t  res_q;
  logic  res_valid;
  logic  advance;
  logic  cfg_write;
  logic [2:0] reg_sel;

  // ---------------------------------------------------------------------------
  // Configuration registers. The APB port never stalls; a write lands on the
  // access cycle. Byte-lane bits of the address are ignored.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freefall_level      <= RST_FREEFALL_LEVEL;
      cfg.impact_level        <= RST_IMPACT_LEVEL;
      cfg.still_accel_level   <= RST_STILL_ACCEL_LEVEL;
      cfg.still_gyro_level    <= RST_STILL_GYRO_LEVEL;
      cfg.tilt_level          <= RST_TILT_LEVEL;
      cfg.freefall_timeout_ms <= RST_FREEFALL_TIMEOUT;
      cfg.still_timeout_ms    <= RST_STILL_TIMEOUT;
      cfg.confirm_hold_ms     <= RST_CONFIRM_HOLD;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FREEFALL_LEVEL:    cfg.freefall_level      <= pwdata[15:0];
        REG_IMPACT_LEVEL:      cfg.impact_level        <= pwdata[15:0];
        REG_STILL_ACCEL_LEVEL: cfg.still_accel_level   <= pwdata[15:0];
        REG_STILL_GYRO_LEVEL:  cfg.still_gyro_level    <= pwdata[15:0];
        REG_TILT_LEVEL:        cfg.tilt_level          <= pwdata[15:0];
        REG_FREEFALL_TIMEOUT:  cfg.freefall_timeout_ms <= pwdata;
        REG_STILL_TIMEOUT:     cfg.still_timeout_ms    <= pwdata;
        REG_CONFIRM_HOLD:      cfg.confirm_hold_ms     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back is combinational from the register select; the narrow
  // thresholds are returned zero-extended.
  always_comb begin
    case (reg_sel)
      REG_FREEFALL_LEVEL:    prdata = {16'd0, cfg.freefall_level};
      REG_IMPACT_LEVEL:      prdata = {16'd0, cfg.impact_level};
      REG_STILL_ACCEL_LEVEL: prdata = {16'd0, cfg.still_accel_level};
      REG_STILL_GYRO_LEVEL:  prdata = {16'd0, cfg.still_gyro_level};
      REG_TILT_LEVEL:        prdata = {16'd0, cfg.tilt_level};
      REG_FREEFALL_TIMEOUT:  prdata = cfg.freefall_timeout_ms;
      REG_STILL_TIMEOUT:     prdata = cfg.still_timeout_ms;
      REG_CONFIRM_HOLD:      prdata = cfg.confirm_hold_ms;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Two-stage pipeline. An item moves from the input register into the result
  // register when the result register is empty or is being emptied this cycle;
  // the detector state is updated at exactly that edge, so items see the
  // state left by the one before them, in order. The input register is free
  // to take a new item whenever its current item moves on, which keeps one
  // item per cycle flowing while results are consumed.
  // ---------------------------------------------------------------------------
  assign advance  = item_valid && (!res_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.req_type        <= req_type;
      item_q.now_ms          <= now_ms;
      item_q.accel_magnitude <= accel_magnitude;
      item_q.gyro_magnitude  <= gyro_magnitude;
      item_q.pitch_angle     <= pitch_angle;
      item_q.roll_angle      <= roll_angle;
    end
  end

  // Next-state and result logic for the item in the input register.
  fdf_step u_step (
    .cfg  (cfg),
    .cur  (fsm),
    .item (item_q),
    .nxt  (fsm_next),
    .res  (res_next)
  );

  // Detector state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm.phase       <= PH_NORMAL;
      fsm.entry_time  <= '0;
      fsm.peak_accel  <= '0;
      fsm.start_pitch <= '0;
      fsm.start_roll  <= '0;
    end else if (advance) begin
      fsm <= fsm_next;
    end
  end

  // Result register: holds its item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid      = res_valid;
  assign fall_state     = res_q.fall_state;
  assign fall_confirmed = res_q.fall_confirmed;
  assign alert_pulse    = res_q.alert_pulse;
  assign confidence_pct = res_q.confidence_pct;
  assign peak_impact    = res_q.peak_impact;
  assign fall_direction = res_q.fall_direction;
  assign state_entry_ms = res_q.state_entry_ms;

endmodule

### hdl/fdf_checker.sv
module fdf_checker
  import fdf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  fall_state,
  input logic        fall_confirmed,
  input logic        alert_pulse,
  input logic [6:0]  confidence_pct
);

  // The confirmed flag follows the reported state.
  a_confirmed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fall_confirmed == (fall_state == PH_CONFIRMED)))
    else $error("confirmed flag disagrees with state");

  // An alert is only raised on a confirmed result.
  a_alert_confirmed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alert_pulse) |-> fall_confirmed)
    else $error("alert without confirmed state");

  // Confidence is tied to the state.
  a_confidence: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((fall_state == PH_NORMAL    && confidence_pct == CONF_NORMAL)   ||
       (fall_state == PH_FREEFALL  && confidence_pct == CONF_FREEFALL) ||
       (fall_state == PH_IMPACT    && confidence_pct == CONF_IMPACT)   ||
       (fall_state == PH_STATIC    && confidence_pct == CONF_STATIC)   ||
       (fall_state == PH_CONFIRMED && confidence_pct == CONF_CONFIRMED)))
    else $error("confidence does not match state");

  // A stalled result keeps its state field.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fall_state)))
    else $error("stalled result changed");

endmodule

bind fall_detect_fsm fdf_checker u_fdf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .fall_state     (fall_state),
  .fall_confirmed (fall_confirmed),
  .alert_pulse    (alert_pulse),
  .confidence_pct (confidence_pct)
);
